// ----- sv/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared constants for the pixel difference compare block.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 4;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

  localparam int ALPHA_CH = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACKGROUND   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_MASK = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARK_VALUE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OPAQUE_ALPHA = 3'd4;

  localparam logic [1:0] BG_NONE   = 2'd0;
  localparam logic [1:0] BG_FIRST  = 2'd1;
  localparam logic [1:0] BG_SECOND = 2'd2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

endpackage

// ----- sv/pixel_difference_compare.sv -----
// ----------------------------------------------------------------------------
// pixel_difference_compare
// Per-channel absolute difference of two RGBA pixels with mark/gain output,
// background fill and running min-nonzero / max difference statistics.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, which loads when the
// output is free. Throughput: one pixel per cycle unless m_tready stalls;
// the min/max trackers are computed between the registers and load with the result.
// Reset: synchronous, active high; clears valids, trackers and registers
// to their defaults (gain 0, background none, mask 15, mark 255, alpha 255).
module pixel_difference_compare (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pdc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_blue, first_green, first_red, first_alpha,
  // second_blue, second_green, second_red, second_alpha
  input  logic [8*pdc_pkg::CHANNEL_BITS-1:0]  s_tdata,
  input  logic                                s_tlast,   // last_pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_blue, out_green, out_red, out_alpha, min_nonzero, max_seen
  output logic [6*pdc_pkg::CHANNEL_BITS-1:0]  m_tdata,
  output logic                                m_tlast    // image_end
);
  import pdc_pkg::*;

  localparam int PROD_BITS = CHANNEL_BITS + GAIN_BITS;

  logic [GAIN_BITS-1:0]    gain;
  logic [1:0]              background_mode;
  logic [NUM_CHANNELS-1:0] channel_mask;
  chan_t                   mark_value;
  chan_t                   opaque_alpha;

  chan_t min_tracker, min_tracker_next;
  chan_t max_tracker, max_tracker_next;

  logic                         in_valid;
  logic [8*CHANNEL_BITS-1:0]    in_data;
  logic                         in_last;
  logic                         adv;

  chan_t                        res [NUM_CHANNELS];
  logic [6*CHANNEL_BITS-1:0]    out_next;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= '0;
      background_mode <= BG_NONE;
      channel_mask    <= '1;
      mark_value      <= CHAN_MAX;
      opaque_alpha    <= CHAN_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:         gain            <= cfg_data;
        REG_BACKGROUND:   background_mode <= cfg_data[1:0];
        REG_CHANNEL_MASK: channel_mask    <= cfg_data[NUM_CHANNELS-1:0];
        REG_MARK_VALUE:   mark_value      <= cfg_data[CHANNEL_BITS-1:0];
        REG_OPAQUE_ALPHA: opaque_alpha    <= cfg_data[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    logic [NUM_CHANNELS-1:0] mask;
    chan_t                   a, b, diff, r;
    logic [PROD_BITS-1:0]    prod;
    logic [PROD_BITS-GAIN_FRAC-1:0] scaled;
    mask             = (channel_mask == '0) ? '1 : channel_mask;
    min_tracker_next = min_tracker;
    max_tracker_next = max_tracker;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      a      = in_data[c*CHANNEL_BITS +: CHANNEL_BITS];
      b      = in_data[(c+NUM_CHANNELS)*CHANNEL_BITS +: CHANNEL_BITS];
      diff   = (a > b) ? (a - b) : (b - a);
      prod   = PROD_BITS'(diff) * PROD_BITS'(gain);
      scaled = prod[PROD_BITS-1:GAIN_FRAC];
      if (gain == '0) begin
        r = (diff == '0) ? '0 : mark_value;
      end else if (|scaled[PROD_BITS-GAIN_FRAC-1:CHANNEL_BITS]) begin
        r = CHAN_MAX;
      end else begin
        r = scaled[CHANNEL_BITS-1:0];
      end
      if (diff == '0) begin
        if (background_mode == BG_FIRST) begin
          r = a;
        end else if (background_mode == BG_SECOND) begin
          r = b;
        end
      end
      if (!mask[c]) begin
        r = '0;
      end else if (diff != '0) begin
        if (min_tracker_next == '0 || diff < min_tracker_next) begin
          min_tracker_next = diff;
        end
        if (diff > max_tracker_next) begin
          max_tracker_next = diff;
        end
      end
      res[c] = r;
    end
    if (!mask[ALPHA_CH]) begin
      res[ALPHA_CH] = opaque_alpha;
    end
    out_next = {max_tracker_next, min_tracker_next,
                res[3], res[2], res[1], res[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_tracker <= '0;
      max_tracker <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (adv) begin
        min_tracker <= in_last ? '0 : min_tracker_next;
        max_tracker <= in_last ? '0 : max_tracker_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= out_next;
      m_tlast <= in_last;
    end
  end

endmodule

// ----- dv/tb_pixel_difference_compare.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_difference_compare
// Drives pixel pairs into the compare block under a series of register
// settings (mark and gain modes, background fill, channel masks) and checks
// every result pixel and the running min/max statistics against an
// in-bench prediction. Both stream sides idle at random, except in the last phases.
// ----------------------------------------------------------------------------
module tb_pixel_difference_compare;
  import pdc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 128;
  localparam logic [1:0] BG_RESERVED = 2'd3;

  typedef struct packed {
    logic                  last;
    logic [3:0][CHANNEL_BITS-1:0] second_ch;
    logic [3:0][CHANNEL_BITS-1:0] first_ch;
  } pixel_pair_t;

  typedef struct packed {
    logic                  image_end;
    chan_t                 max_d;
    chan_t                 min_nz;
    logic [3:0][CHANNEL_BITS-1:0] ch;
  } diff_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [8*CHANNEL_BITS-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [6*CHANNEL_BITS-1:0] m_tdata;
  logic m_tlast;

  pixel_difference_compare dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // register copy and statistics state
  logic [GAIN_BITS-1:0] gain_q = '0;
  logic [1:0]           bg_q = BG_NONE;
  logic [3:0]           mask_q = 4'hF;
  chan_t                mark_q = CHAN_MAX;
  chan_t                opaque_q = CHAN_MAX;
  chan_t                min_trk = '0;
  chan_t                max_trk = '0;

  pixel_pair_t  pixel_q[$];
  diff_result_t expected_diff_q[$];
  int issued_count = 0;
  int result_count = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 17;
  int recv_idle_pct = 80;

  function automatic diff_result_t compute_diff(input pixel_pair_t px);
    diff_result_t r;
    logic [3:0] sel;
    chan_t a, b, d, v;
    logic [23:0] prod;
    sel = (mask_q == 4'h0) ? 4'hF : mask_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      a = px.first_ch[c];
      b = px.second_ch[c];
      if (!sel[c]) begin
        r.ch[c] = '0;
      end else begin
        d = (a > b) ? a - b : b - a;
        if (d != 0) begin
          if (min_trk == 0 || d < min_trk) min_trk = d;
          if (d > max_trk) max_trk = d;
        end
        if (gain_q == 0) begin
          v = (d == 0) ? '0 : mark_q;
        end else begin
          prod = d * gain_q;
          v = (prod[23:GAIN_FRAC] > CHAN_MAX) ? CHAN_MAX : prod[GAIN_FRAC +: CHANNEL_BITS];
        end
        if (d == 0) begin
          if (bg_q == BG_FIRST) v = a;
          else if (bg_q == BG_SECOND) v = b;
        end
        r.ch[c] = v;
      end
    end
    if (!sel[ALPHA_CH]) r.ch[ALPHA_CH] = opaque_q;
    r.min_nz = min_trk;
    r.max_d = max_trk;
    r.image_end = px.last;
    if (px.last) begin
      min_trk = '0;
      max_trk = '0;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        {s_tlast, s_tdata} <= pixel_q.pop_front();
        s_tvalid <= 1'b1;
        issued_count++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // input monitor: predict on every accepted request
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_diff_q.insert(expected_diff_q.size(),
                             compute_diff(pixel_pair_t'({s_tlast, s_tdata})));
  end

  // output monitor
  always @(posedge clk) begin : check_results
    diff_result_t want, got;
    logic bad;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      got = diff_result_t'({m_tlast, m_tdata});
      if (expected_diff_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_diff_q.pop_front();
        bad = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
          if (got.ch[c] !== want.ch[c]) bad = 1'b1;
        if (got.min_nz !== want.min_nz) bad = 1'b1;
        if (got.max_d !== want.max_d) bad = 1'b1;
        if (got.image_end !== want.image_end) bad = 1'b1;
        if (bad) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp ch %h min %h max %h end %b, got ch %h min %h max %h end %b",
                     want.ch, want.min_nz, want.max_d, want.image_end,
                     got.ch, got.min_nz, got.max_d, got.image_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_pixel_difference_compare NOT OK");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GAIN:         gain_q = val;
      REG_BACKGROUND:   bg_q = val[1:0];
      REG_CHANNEL_MASK: mask_q = val[3:0];
      REG_MARK_VALUE:   mark_q = val[7:0];
      REG_OPAQUE_ALPHA: opaque_q = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pair(input logic [31:0] f, input logic [31:0] s, input logic last);
    pixel_pair_t p;
    p.first_ch = f;
    p.second_ch = s;
    p.last = last;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || issued_count != result_count) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [GAIN_BITS-1:0] g;
    logic [1:0] bg;
    logic [3:0] mk;
    chan_t mv, oa, a, b;
    pixel_pair_t p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        sender_idle_pct = 80;
        recv_idle_pct = 17;
      end else if (ph == 6) begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        case (ph)
          1: begin g = 16'h0100; bg = BG_FIRST;    mk = 4'hF; mv = 8'h00; oa = 8'h00; end
          2: begin g = 16'hFFFF; bg = BG_SECOND;   mk = 4'h5; mv = 8'h80; oa = 8'h7F; end
          3: begin g = 16'h0000; bg = BG_RESERVED; mk = 4'h0; mv = 8'h01; oa = 8'hFF; end
          4: begin g = 16'h0001; bg = BG_NONE;     mk = 4'h7; mv = 8'hFF; oa = 8'h00; end
          default: begin
            g = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(1023));
            if ($urandom_range(3) == 0) g = '0;
            bg = 2'($urandom_range(3));
            mk = 4'($urandom_range(15));
            mv = 8'($urandom_range(255));
            oa = 8'($urandom_range(255));
          end
        endcase
        write_reg(REG_GAIN, g);
        write_reg(REG_BACKGROUND, 16'(bg));
        write_reg(REG_CHANNEL_MASK, 16'(mk));
        write_reg(REG_MARK_VALUE, 16'(mv));
        write_reg(REG_OPAQUE_ALPHA, 16'(oa));
      end
      if (ph == 0) begin
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_pair(32'h0102_0304, 32'h0202_0203, 1'b0);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_pair(32'h807F_01FE, 32'h7F80_FE01, 1'b0);
      end else begin
        queue_pair(32'h00FF_1080, 32'h00FF_2070, 1'b0);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          case ($urandom_range(7))
            0: a = '0;
            1: a = CHAN_MAX;
            default: a = 8'($urandom_range(255));
          endcase
          case ($urandom_range(5))
            0, 1: b = a;
            2: b = a + 8'($urandom_range(3)) - 8'd1;
            3: b = ($urandom_range(1) == 0) ? 8'h00 : CHAN_MAX;
            default: b = 8'($urandom_range(255));
          endcase
          p.first_ch[c] = a;
          p.second_ch[c] = b;
        end
        p.last = ($urandom_range(15) == 0);
        pixel_q.insert(pixel_q.size(), p);
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_diff_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("tb_pixel_difference_compare OK");
    end else begin
      $display("tb_pixel_difference_compare NOT OK");
    end
    $finish;
  end

endmodule
